// ===== rtl/fkp_pkg.sv =====
package fkp_pkg;

    // Widths of the fixed fields.
    localparam int LEN_W   = 15;
    localparam int Q15_W   = 16;
    localparam int POS_W   = 18;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 34;
    localparam int WIDE_W  = 50;

    // CORDIC number formats: angle accumulator Q29, x and y Q30.
    localparam int ZFRAC        = 29;
    localparam int ATAN_ENTRIES = 24;

    typedef logic signed [31:0]       t_xy;
    typedef logic signed [31:0]       t_z;
    typedef logic signed [Q15_W-1:0]  t_q15;
    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic [LEN_W-1:0]         t_len;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam longint PI_Z      = 64'sd1686629713;
    localparam t_z     HALF_PI_Z = 32'sd843314857;
    localparam t_z     PI_Z32    = 32'sd1686629713;
    localparam t_xy    GAIN_Q30  = 32'sd652032874;

    // Arctangent of 2^-i in Q29.
    localparam t_z ATAN_Z [ATAN_ENTRIES] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510844,  32'sd16771757,  32'sd8387925,   32'sd4194219,
        32'sd2097142,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64
    };

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_UPPER_LEN  = 2'd0,
        CFG_FOREARM    = 2'd1,
        CFG_HAND       = 2'd2,
        CFG_SH_OFFSET  = 2'd3
    } t_cfg_idx;

    // Undo the fold, round a Q30 value half up to Q1.15 and saturate.
    function automatic t_q15 f_q15(input t_xy v, input logic flip);
        logic signed [32:0] n;
        logic signed [32:0] t;
        begin
            n = flip ? -33'(v) : 33'(v);
            t = (n + 33'sd16384) >>> 15;
            if (t > 33'sd32767) begin
                f_q15 = 16'sh7fff;
            end else if (t < -33'sd32768) begin
                f_q15 = 16'sh8000;
            end else begin
                f_q15 = t_q15'(t[Q15_W-1:0]);
            end
        end
    endfunction

    // Round half up by s bits and saturate to the position range.
    function automatic t_pos f_pos(input t_wide v, input int unsigned s);
        logic signed [WIDE_W:0] t;
        begin
            t = {v[WIDE_W-1], v} + ((WIDE_W+1)'(1) <<< (s - 1));
            t = t >>> s;
            if (t > (WIDE_W+1)'(131071)) begin
                f_pos = 18'sh1ffff;
            end else if (t < -(WIDE_W+1)'(131072)) begin
                f_pos = 18'sh20000;
            end else begin
                f_pos = t_pos'(t[POS_W-1:0]);
            end
        end
    endfunction

endpackage

// ===== rtl/fkp_cordic_cell.sv =====
module fkp_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic          i_clk,
    input  fkp_pkg::t_xy  i_x,
    input  fkp_pkg::t_xy  i_y,
    input  fkp_pkg::t_z   i_z,
    input  logic          i_flip,
    output fkp_pkg::t_xy  o_x,
    output fkp_pkg::t_xy  o_y,
    output fkp_pkg::t_z   o_z,
    output logic          o_flip
);
    import fkp_pkg::*;

    localparam t_z ATAN = ATAN_Z[SHIFT];

    t_xy r_x, n_x;
    t_xy r_y, n_y;
    t_z  r_z, n_z;
    logic r_flip;

    // One rotation towards zero residual angle.
    always_comb begin
        if (i_z >= 0) begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_flip <= i_flip;
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_flip = r_flip;

endmodule

// ===== rtl/arm_forward_kinematics_position.sv =====
// End-effector position of a four-joint arm from its joint angles. A new set
// of angles is taken in every cycle (busy stays low), and each result appears
// on o_pos_x, o_pos_y and o_pos_z with o_valid high for one cycle; the
// receiver cannot hold it off. Each set passes through two stages of angle
// wrapping, then the chain of CORDIC cells, one rotation per cell, then five
// stages of products, sums and rounding. Configuration writes take effect at
// once and are meant to be made while no item is in flight.
module arm_forward_kinematics_position #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_WIDTH   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [ANGLE_WIDTH-1:0] i_base_angle,
    input  logic signed [ANGLE_WIDTH-1:0] i_shoulder_angle,
    input  logic signed [ANGLE_WIDTH-1:0] i_elbow_angle,
    input  logic signed [ANGLE_WIDTH-1:0] i_wrist_pitch_angle,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [(ANGLE_WIDTH > 15 ? ANGLE_WIDTH : 15)-1:0] i_cfg_data,
    output logic                          o_valid,
    output fkp_pkg::t_pos                 o_pos_x,
    output fkp_pkg::t_pos                 o_pos_y,
    output fkp_pkg::t_pos                 o_pos_z
);
    import fkp_pkg::*;

    localparam int AW     = ANGLE_WIDTH;
    localparam int ZSHIFT = ZFRAC - (AW - 3);
    localparam longint PI_A = (PI_Z + (longint'(1) << (ZSHIFT - 1))) >> ZSHIFT;
    localparam logic signed [AW+1:0] PI_W     = (AW+2)'(PI_A);
    localparam logic signed [AW+1:0] TWO_PI_W = (AW+2)'(2 * PI_A);
    localparam int LANES = 4;
    localparam int VLEN  = CORDIC_STAGES + 7;

    // Wrap an angle sum into [-pi, pi).
    function automatic logic signed [AW-1:0] f_wrap(input logic signed [AW+1:0] v);
        logic signed [AW+1:0] t;
        begin
            t = v;
            if (t >= PI_W) begin
                t = t - TWO_PI_W;
            end
            if (t >= PI_W) begin
                t = t - TWO_PI_W;
            end
            if (t < -PI_W) begin
                t = t + TWO_PI_W;
            end
            if (t < -PI_W) begin
                t = t + TWO_PI_W;
            end
            f_wrap = t[AW-1:0];
        end
    endfunction

    // Configuration registers.
    t_len r_len_a;
    t_len r_len_b;
    t_len r_len_c;
    logic signed [AW-1:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a  <= 15'd13194;
            r_len_b  <= 15'd12800;
            r_len_c  <= 15'd11146;
            r_offset <= AW'(1967);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_UPPER_LEN: r_len_a  <= i_cfg_data[LEN_W-1:0];
                CFG_FOREARM:   r_len_b  <= i_cfg_data[LEN_W-1:0];
                CFG_HAND:      r_len_c  <= i_cfg_data[LEN_W-1:0];
                CFG_SH_OFFSET: r_offset <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so an item is taken whenever start is high.
    logic w_accept;
    logic [VLEN-1:0] r_vld;

    assign busy     = 1'b0;
    assign w_accept = start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VLEN-2:0], w_accept};
        end
    end

    // Angle sums, wrapped. Lane 0 base, 1 s+e+w, 2 s+e, 3 s-offset.
    logic signed [AW-1:0] r_ang [LANES];

    always_ff @(posedge i_clk) begin
        r_ang[0] <= f_wrap((AW+2)'(i_base_angle));
        r_ang[1] <= f_wrap((AW+2)'(i_shoulder_angle) + (AW+2)'(i_elbow_angle)
                           + (AW+2)'(i_wrist_pitch_angle));
        r_ang[2] <= f_wrap((AW+2)'(i_shoulder_angle) + (AW+2)'(i_elbow_angle));
        r_ang[3] <= f_wrap((AW+2)'(i_shoulder_angle) - (AW+2)'(r_offset));
    end

    // CORDIC chains, one per lane, after folding into [-pi/2, pi/2].
    t_xy  c_x    [LANES][CORDIC_STAGES+1];
    t_xy  c_y    [LANES][CORDIC_STAGES+1];
    t_z   c_z    [LANES][CORDIC_STAGES+1];
    logic c_flip [LANES][CORDIC_STAGES+1];
    t_q15 r_sin  [LANES];
    t_q15 r_cos  [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        t_z   w_z;
        t_z   r_bz;
        logic r_bflip;

        assign w_z = t_z'(r_ang[l]) <<< ZSHIFT;

        always_ff @(posedge i_clk) begin
            if (w_z > HALF_PI_Z) begin
                r_bz    <= w_z - PI_Z32;
                r_bflip <= 1'b1;
            end else if (w_z < -HALF_PI_Z) begin
                r_bz    <= w_z + PI_Z32;
                r_bflip <= 1'b1;
            end else begin
                r_bz    <= w_z;
                r_bflip <= 1'b0;
            end
        end

        assign c_x[l][0]    = GAIN_Q30;
        assign c_y[l][0]    = '0;
        assign c_z[l][0]    = r_bz;
        assign c_flip[l][0] = r_bflip;

        for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
            fkp_cordic_cell #(
                .SHIFT(k)
            ) u_cell (
                .i_clk  (i_clk),
                .i_x    (c_x[l][k]),
                .i_y    (c_y[l][k]),
                .i_z    (c_z[l][k]),
                .i_flip (c_flip[l][k]),
                .o_x    (c_x[l][k+1]),
                .o_y    (c_y[l][k+1]),
                .o_z    (c_z[l][k+1]),
                .o_flip (c_flip[l][k+1])
            );
        end

        // Round the chain output to Q1.15.
        always_ff @(posedge i_clk) begin
            r_cos[l] <= f_q15(c_x[l][CORDIC_STAGES], c_flip[l][CORDIC_STAGES]);
            r_sin[l] <= f_q15(c_y[l][CORDIC_STAGES], c_flip[l][CORDIC_STAGES]);
        end
    end

    // Link length times sine or cosine.
    logic signed [PROD_W-1:0] r_mr0, r_mr1, r_mr2, r_mz0, r_mz1, r_mz2;
    t_q15 r_cb2, r_sb2, r_cb3, r_sb3;
    logic signed [Q15_W-1:0] w_a, w_b, w_c;

    assign w_a = signed'({1'b0, r_len_a});
    assign w_b = signed'({1'b0, r_len_b});
    assign w_c = signed'({1'b0, r_len_c});

    always_ff @(posedge i_clk) begin
        r_mr0 <= w_c * r_cos[1];
        r_mr1 <= w_b * r_cos[2];
        r_mr2 <= w_a * r_sin[3];
        r_mz0 <= w_c * r_sin[1];
        r_mz1 <= w_b * r_sin[2];
        r_mz2 <= w_a * r_cos[3];
        r_cb2 <= r_cos[0];
        r_sb2 <= r_sin[0];
    end

    // Reach and height sums.
    logic signed [SUM_W-1:0] r_reach, r_zsum;

    always_ff @(posedge i_clk) begin
        r_reach <= SUM_W'(r_mr0) - SUM_W'(r_mr1) - SUM_W'(r_mr2);
        r_zsum  <= SUM_W'(r_mz1) - SUM_W'(r_mz0) - SUM_W'(r_mz2);
        r_cb3   <= r_cb2;
        r_sb3   <= r_sb2;
    end

    // Reach projected onto x and y; height rounded.
    t_wide r_px, r_py;
    t_pos  r_zq;

    always_ff @(posedge i_clk) begin
        r_px <= r_reach * r_cb3;
        r_py <= r_reach * r_sb3;
        r_zq <= f_pos(WIDE_W'(r_zsum), 15);
    end

    // Output registers.
    always_ff @(posedge i_clk) begin
        o_pos_x <= f_pos(r_px, 30);
        o_pos_y <= f_pos(r_py, 30);
        o_pos_z <= r_zq;
    end

    assign o_valid = r_vld[VLEN-1];

endmodule
